@@ hw/rtl/ccw_pkg.sv @@
// Shared types and constants for the text console cell writer.
// No dependencies; the other RTL files except ccw_fifo refer to this package by scoped names.
package ccw_pkg;

    // Widest cell address the parameter range allows (128 x 32 cells)
    localparam int MaxAw = 12;

    // Input operation codes
    localparam logic [2:0] OpPutCursor = 3'd0;
    localparam logic [2:0] OpPutPos    = 3'd1;
    localparam logic [2:0] OpBackspace = 3'd2;
    localparam logic [2:0] OpClear     = 3'd3;
    localparam logic [2:0] OpRead      = 3'd4;

    // Configuration register indexes
    localparam logic CfgFg = 1'b0;
    localparam logic CfgBg = 1'b1;

    // Character and color constants
    localparam logic [7:0] ChNewline = 8'd10;
    localparam logic [7:0] ChSpace   = 8'd32;
    localparam logic [7:0] ChError   = 8'd69;
    localparam logic [3:0] ColorRed  = 4'd4;

    // Command class decided by the front end
    typedef enum logic [2:0] {
        K_PUT,
        K_ERR_PUT,
        K_BACKSPACE,
        K_CLEAR,
        K_READ,
        K_NONE
    } t_kind;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SCROLL,
        ST_BLANK,
        ST_CLEAR
    } t_state;

    // Classified command, front to back
    typedef struct packed {
        t_kind              kind;
        logic               at_cursor;
        logic               bad;
        logic [7:0]         ch;
        logic [6:0]         col;
        logic [MaxAw-1:0]   pos;
    } t_cmd;

    // Result item
    typedef struct packed {
        logic [10:0] cursor;
        logic        bad_position;
        logic [7:0]  cell_char;
        logic [7:0]  cell_attr;
    } t_res;

endpackage

@@ hw/rtl/text_console_cell_writer_core.sv @@
// Top level of the text console cell writer: configuration registers and
// result queue around the front end and back end. Depends on ccw_pkg,
// ccw_fifo, ccw_front and ccw_back.
//
// A character-cell screen of COLUMNS x ROWS cells held in one memory with a
// single write port. Puts, newlines, backspaces, out-of-range puts and
// unused ops each finish in the idle state of the back end, so a stream of
// them runs at one item per clock while the result queue has room; a cell
// read adds a read state for its registered memory read. A put or newline
// that passes the last cell scrolls the screen; scroll and clear both walk
// the memory one cell per cycle through its single write port. Input items
// queue in a two-entry command queue during a walk, results in a two-entry
// result queue. The screen is not cleared after reset: issue a clear
// before reading cells. Configuration (fg at index 0, bg at index 1) is
// always ready and should be written only while no item is in flight.
module text_console_cell_writer_core #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input queue side
    input  logic        push,
    output logic        full,
    input  logic [2:0]  i_op,
    input  logic [7:0]  i_char_code,
    input  logic [6:0]  i_column,
    input  logic [4:0]  i_row,
    // Result queue side
    input  logic        pop,
    output logic        empty,
    output logic [10:0] o_cursor,
    output logic        o_bad_position,
    output logic [7:0]  o_cell_char,
    output logic [7:0]  o_cell_attr,
    // Configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [3:0]  i_cfg_data
);
    logic [3:0]    r_fg;
    logic [3:0]    r_bg;
    logic          w_cmd_valid;
    logic          w_cmd_pop;
    ccw_pkg::t_cmd w_cmd;
    logic          w_res_full;
    logic          w_res_push;
    ccw_pkg::t_res w_res_in;
    ccw_pkg::t_res w_res_out;

    // Color registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg <= 4'd15;
            r_bg <= 4'd0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                ccw_pkg::CfgFg: r_fg <= i_cfg_data;
                ccw_pkg::CfgBg: r_bg <= i_cfg_data;
                default: ;
            endcase
        end
    end

    ccw_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_op        (i_op),
        .i_char_code (i_char_code),
        .i_column    (i_column),
        .i_row       (i_row),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_pop   (w_cmd_pop),
        .o_cmd       (w_cmd)
    );

    ccw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .i_fg        (r_fg),
        .i_bg        (r_bg),
        .i_res_full  (w_res_full),
        .o_res_push  (w_res_push),
        .o_res       (w_res_in)
    );

    // Result queue
    ccw_fifo #(
        .W     ($bits(ccw_pkg::t_res)),
        .DEPTH (2)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res_in),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_data  (w_res_out),
        .o_empty (empty)
    );

    assign o_cursor       = w_res_out.cursor;
    assign o_bad_position = w_res_out.bad_position;
    assign o_cell_char    = w_res_out.cell_char;
    assign o_cell_attr    = w_res_out.cell_attr;
endmodule

@@ hw/rtl/ccw_fifo.sv @@
// Small register queue used for the command and result queues.
// No package dependency; depth must be a power of two.
module ccw_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [W-1:0]         r_data [DEPTH];
    logic [PW-1:0]        r_wp;
    logic [PW-1:0]        r_rp;
    logic [$clog2(DEPTH+1)-1:0] r_cnt;
    logic                 w_wr;
    logic                 w_rd;

    assign o_full  = (r_cnt == ($clog2(DEPTH+1))'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_data  = r_data[r_rp];

    // Storage
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_data[r_wp] <= i_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_rd) begin
                r_rp <= r_rp + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule

@@ hw/rtl/ccw_front.sv @@
// Front end: accepts input items, classifies them and queues commands.
// Depends on ccw_pkg and ccw_fifo.
module ccw_front #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_full,
    input  logic [2:0]    i_op,
    input  logic [7:0]    i_char_code,
    input  logic [6:0]    i_column,
    input  logic [4:0]    i_row,
    output logic          o_cmd_valid,
    input  logic          i_cmd_pop,
    output ccw_pkg::t_cmd o_cmd
);
    localparam logic [7:0] ColLimit = 8'(COLUMNS);
    localparam logic [5:0] RowLimit = 6'(ROWS);

    ccw_pkg::t_cmd                  w_cmd;
    logic                           w_outside;
    logic [ccw_pkg::MaxAw-1:0]      w_pos;
    logic                           w_empty;

    // Range check and linear cell address
    assign w_outside = ({1'b0, i_column} >= ColLimit) || ({1'b0, i_row} >= RowLimit);
    assign w_pos     = ccw_pkg::MaxAw'(i_row) * ccw_pkg::MaxAw'(COLUMNS)
                     + ccw_pkg::MaxAw'(i_column);

    // Classify
    always_comb begin
        w_cmd           = '0;
        w_cmd.ch        = i_char_code;
        w_cmd.col       = i_column;
        w_cmd.pos       = w_pos;
        w_cmd.kind      = ccw_pkg::K_NONE;
        unique case (i_op)
            ccw_pkg::OpPutCursor: begin
                w_cmd.kind      = ccw_pkg::K_PUT;
                w_cmd.at_cursor = 1'b1;
            end
            ccw_pkg::OpPutPos: begin
                w_cmd.kind = w_outside ? ccw_pkg::K_ERR_PUT : ccw_pkg::K_PUT;
            end
            ccw_pkg::OpBackspace: w_cmd.kind = ccw_pkg::K_BACKSPACE;
            ccw_pkg::OpClear:     w_cmd.kind = ccw_pkg::K_CLEAR;
            ccw_pkg::OpRead: begin
                w_cmd.kind = w_outside ? ccw_pkg::K_NONE : ccw_pkg::K_READ;
                w_cmd.bad  = w_outside;
            end
            default: w_cmd.kind = ccw_pkg::K_NONE;
        endcase
    end

    // Command queue toward the back end
    ccw_fifo #(
        .W     ($bits(ccw_pkg::t_cmd)),
        .DEPTH (2)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (w_cmd),
        .o_full  (o_full),
        .i_pop   (i_cmd_pop),
        .o_data  (o_cmd),
        .o_empty (w_empty)
    );

    assign o_cmd_valid = !w_empty;
endmodule

@@ hw/rtl/ccw_back.sv @@
// Back end: screen memory, cursor and the sequencer for scroll and clear.
// Depends on ccw_pkg.
module ccw_back #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  ccw_pkg::t_cmd i_cmd,
    output logic          o_cmd_pop,
    input  logic [3:0]    i_fg,
    input  logic [3:0]    i_bg,
    input  logic          i_res_full,
    output logic          o_res_push,
    output ccw_pkg::t_res o_res
);
    localparam int Cells = COLUMNS * ROWS;
    localparam int AW    = $clog2(Cells);
    localparam logic [AW-1:0] LastCell = AW'(Cells - 1);
    localparam logic [AW-1:0] CopyEnd  = AW'(Cells - COLUMNS);
    localparam logic [AW-1:0] ColsA    = AW'(COLUMNS);
    localparam logic [AW:0]   CellsW   = (AW+1)'(Cells);
    localparam logic [AW:0]   ColsW    = (AW+1)'(COLUMNS);
    localparam logic [6:0]    ColLast  = 7'(COLUMNS - 1);

    logic [15:0]      r_mem [Cells];
    logic [15:0]      r_rd_data;
    ccw_pkg::t_state  r_state, n_state;
    logic [AW-1:0]    r_idx, n_idx;
    logic [AW-1:0]    r_cursor, n_cursor;
    logic [6:0]       r_col, n_col;

    logic             w_we;
    logic [AW-1:0]    w_wa;
    logic [15:0]      w_wd;
    logic             w_re;
    logic [AW-1:0]    w_ra;
    logic [AW-1:0]    w_pos;
    logic [6:0]       w_col;
    logic [7:0]       w_attr;
    logic [AW:0]      w_next;

    assign w_attr = {i_bg, i_fg};
    assign w_pos  = i_cmd.at_cursor ? r_cursor : i_cmd.pos[AW-1:0];
    assign w_col  = i_cmd.at_cursor ? r_col : i_cmd.col;

    // Screen memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        if (w_re) begin
            r_rd_data <= r_mem[w_ra];
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ccw_pkg::ST_IDLE;
            r_idx    <= '0;
            r_cursor <= '0;
            r_col    <= '0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_cursor <= n_cursor;
            r_col    <= n_col;
        end
    end

    // Sequencer: next state, memory access and result
    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_cursor   = r_cursor;
        n_col      = r_col;
        w_we       = 1'b0;
        w_wa       = r_idx;
        w_wd       = '0;
        w_re       = 1'b0;
        w_ra       = r_idx;
        w_next     = '0;
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;
        o_res      = '0;
        o_res.cursor = 11'(r_cursor);

        unique case (r_state)
            ccw_pkg::ST_IDLE: begin
                if (i_cmd_valid && !i_res_full) begin
                    o_cmd_pop = 1'b1;
                    unique case (i_cmd.kind)
                        ccw_pkg::K_PUT: begin
                            if (i_cmd.ch == ccw_pkg::ChNewline) begin
                                w_next = {1'b0, w_pos} - (AW+1)'(w_col) + ColsW;
                                n_col  = '0;
                            end else begin
                                w_we   = 1'b1;
                                w_wa   = w_pos;
                                w_wd   = {w_attr, i_cmd.ch};
                                w_next = {1'b0, w_pos} + 1'b1;
                                n_col  = (w_col == ColLast) ? '0 : w_col + 7'd1;
                            end
                            // Past the last cell: scroll before reporting
                            if (w_next >= CellsW) begin
                                n_cursor = AW'(w_next - ColsW);
                                n_idx    = '0;
                                n_state  = ccw_pkg::ST_SCROLL;
                            end else begin
                                n_cursor     = w_next[AW-1:0];
                                o_res_push   = 1'b1;
                                o_res.cursor = 11'(w_next[AW-1:0]);
                            end
                        end
                        ccw_pkg::K_ERR_PUT: begin
                            w_we               = 1'b1;
                            w_wa               = LastCell;
                            w_wd               = {i_fg, ccw_pkg::ColorRed, ccw_pkg::ChError};
                            o_res_push         = 1'b1;
                            o_res.bad_position = 1'b1;
                        end
                        ccw_pkg::K_BACKSPACE: begin
                            if (r_cursor != '0) begin
                                w_we         = 1'b1;
                                w_wa         = r_cursor - 1'b1;
                                w_wd         = {w_attr, ccw_pkg::ChSpace};
                                n_cursor     = r_cursor - 1'b1;
                                n_col        = (r_col == '0) ? ColLast : r_col - 7'd1;
                                o_res.cursor = 11'(r_cursor - 1'b1);
                            end
                            o_res_push = 1'b1;
                        end
                        ccw_pkg::K_CLEAR: begin
                            n_cursor = '0;
                            n_col    = '0;
                            n_idx    = '0;
                            n_state  = ccw_pkg::ST_CLEAR;
                        end
                        ccw_pkg::K_READ: begin
                            w_re    = 1'b1;
                            w_ra    = i_cmd.pos[AW-1:0];
                            n_state = ccw_pkg::ST_READ;
                        end
                        default: begin
                            o_res_push         = 1'b1;
                            o_res.bad_position = i_cmd.bad;
                        end
                    endcase
                end
            end
            ccw_pkg::ST_READ: begin
                o_res_push      = 1'b1;
                o_res.cell_char = r_rd_data[7:0];
                o_res.cell_attr = r_rd_data[15:8];
                n_state         = ccw_pkg::ST_IDLE;
            end
            // Move rows up: read one row ahead, write the cell fetched last cycle
            ccw_pkg::ST_SCROLL: begin
                w_re = (r_idx != CopyEnd);
                w_ra = r_idx + ColsA;
                w_we = (r_idx != '0);
                w_wa = r_idx - 1'b1;
                w_wd = r_rd_data;
                if (r_idx == CopyEnd) begin
                    n_state = ccw_pkg::ST_BLANK;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            // Zero the bottom row
            ccw_pkg::ST_BLANK: begin
                w_we = 1'b1;
                w_wa = r_idx;
                w_wd = '0;
                if (r_idx == LastCell) begin
                    o_res_push = 1'b1;
                    n_state    = ccw_pkg::ST_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ccw_pkg::ST_CLEAR: begin
                w_we = 1'b1;
                w_wa = r_idx;
                w_wd = {w_attr, ccw_pkg::ChSpace};
                if (r_idx == LastCell) begin
                    o_res_push = 1'b1;
                    n_state    = ccw_pkg::ST_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            default: n_state = ccw_pkg::ST_IDLE;
        endcase
    end

    // Checks
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |-> !i_res_full)
        else $error("result pushed into a full queue");

    a_cursor_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cursor <= LastCell) && (r_col <= ColLast))
        else $error("cursor outside the screen");

    a_one_result_per_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ccw_pkg::ST_SCROLL || r_state == ccw_pkg::ST_READ) |-> !o_cmd_pop)
        else $error("command taken while a walk is in progress");

    a_clear_homes_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ccw_pkg::ST_CLEAR && o_res_push) |-> (r_cursor == '0 && r_col == '0))
        else $error("clear finished with the cursor away from home");
endmodule
